// File: hdl/fcp_pkg.sv
// shared widths, constants, result and step types and decimal fold of the framed command parser
`default_nettype none
package fcp_pkg;
	localparam int BYTE_W = 8;
	localparam int VALUE_W = 16;
	localparam logic [BYTE_W-1:0] HEADER_RESET = 8'h00;
	localparam logic [BYTE_W-1:0] CNT_AFTER_HEADER = 8'd1;
	localparam logic [BYTE_W-1:0] CNT_AFTER_LENGTH = 8'd2;
	localparam logic [BYTE_W-1:0] CNT_COMMAND = 8'd3;

	typedef struct packed {
		logic [BYTE_W-1:0]  command_id;
		logic [VALUE_W-1:0] payload_value;
		logic [BYTE_W-1:0]  frame_length;
	} result_t;

	typedef struct packed {
		logic              valid;
		logic [BYTE_W-1:0] data;
	} step_t;

	// value*10 + byte, modulo 2^16
	function automatic logic [VALUE_W-1:0] dec_fold(input logic [VALUE_W-1:0] acc,
			input logic [BYTE_W-1:0] b);
		logic [VALUE_W-1:0] times_ten;
		times_ten = (acc << 3) + (acc << 1);
		return times_ten + {{(VALUE_W-BYTE_W){1'b0}}, b};
	endfunction
endpackage
`default_nettype wire

// File: hdl/fcp_parse_core.sv
// frame state machine: header hunt, length, command and payload folding
`default_nettype none
module fcp_parse_core (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic [fcp_pkg::BYTE_W-1:0] header_byte,
	input  wire fcp_pkg::step_t         step,
	input  wire logic                   out_free,
	output logic                        consume,
	output logic                        emit,
	output fcp_pkg::result_t            result
);
	typedef enum logic [1:0] {
		PH_HUNT,
		PH_LEN,
		PH_DATA
	} phase_t;

	phase_t                        phase_q;
	logic [fcp_pkg::BYTE_W-1:0]    count_q;
	logic [fcp_pkg::BYTE_W-1:0]    length_q;
	logic [fcp_pkg::BYTE_W-1:0]    command_q;
	logic [fcp_pkg::VALUE_W-1:0]   acc_q;

	logic [fcp_pkg::BYTE_W-1:0]    count_next;
	logic [fcp_pkg::BYTE_W-1:0]    command_next;
	logic [fcp_pkg::VALUE_W-1:0]   acc_next;
	logic                          frame_end;

	always_comb begin
		count_next = count_q + 8'd1;
		if (count_next == fcp_pkg::CNT_COMMAND) begin
			command_next = step.data;
			acc_next = acc_q;
		end else begin
			command_next = command_q;
			acc_next = fcp_pkg::dec_fold(acc_q, step.data);
		end
		frame_end = (phase_q == PH_DATA) && (count_next >= length_q);
		emit = step.valid && frame_end;
		consume = !frame_end || out_free;
		result.command_id = command_next;
		result.payload_value = acc_next;
		result.frame_length = length_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			count_q <= '0;
			length_q <= '0;
			command_q <= '0;
			acc_q <= '0;
		end else if (step.valid && consume) begin
			unique case (phase_q)
				PH_LEN: begin
					length_q <= step.data;
					count_q <= fcp_pkg::CNT_AFTER_LENGTH;
					phase_q <= PH_DATA;
				end
				PH_DATA: begin
					if (frame_end) begin
						phase_q <= PH_HUNT;
						count_q <= '0;
						length_q <= '0;
						command_q <= '0;
						acc_q <= '0;
					end else begin
						count_q <= count_next;
						command_q <= command_next;
						acc_q <= acc_next;
					end
				end
				default: begin
					if (step.data == header_byte) begin
						phase_q <= PH_LEN;
						count_q <= fcp_pkg::CNT_AFTER_HEADER;
						length_q <= '0;
						command_q <= '0;
						acc_q <= '0;
					end else begin
						phase_q <= PH_HUNT;
					end
				end
			endcase
		end
	end
endmodule
`default_nettype wire

// File: hdl/framed_command_parser.sv
// top level of the framed command parser: input register, core, result register
//
// channel | direction | handshake          | payload
// cfg     | in        | cfg_we             | cfg_wdata (header byte)
// in      | in        | in_valid/in_ready  | rx_byte
// out     | out       | out_valid/out_ready| command_id, payload_value, frame_length
//
// one beat per cycle but while the input register stalls; a result is valid
// once its last byte has passed the input register, then the result register
// the input register stalls only while a frame-ending byte waits on a full,
// stalled result register
// asynchronous reset returns the parser to header hunt and the header byte to 0
`default_nettype none
module framed_command_parser (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [fcp_pkg::BYTE_W-1:0]    cfg_wdata,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [fcp_pkg::BYTE_W-1:0]    rx_byte,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [fcp_pkg::BYTE_W-1:0]         command_id,
	output logic [fcp_pkg::VALUE_W-1:0]        payload_value,
	output logic [fcp_pkg::BYTE_W-1:0]         frame_length
);
	logic [fcp_pkg::BYTE_W-1:0] header_q;
	logic                       valid_s1;
	logic [fcp_pkg::BYTE_W-1:0] byte_s1;
	logic                       valid_s2;
	fcp_pkg::result_t           result_s2;

	fcp_pkg::step_t             step;
	fcp_pkg::result_t           core_result;
	logic                       out_free;
	logic                       consume;
	logic                       emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q <= fcp_pkg::HEADER_RESET;
		end else if (cfg_we) begin
			header_q <= cfg_wdata;
		end
	end

	assign out_free = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || consume;
	assign step.valid = valid_s1;
	assign step.data = byte_s1;

	fcp_parse_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.header_byte (header_q),
		.step        (step),
		.out_free    (out_free),
		.consume     (consume),
		.emit        (emit),
		.result      (core_result)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && emit) begin
			result_s2 <= core_result;
		end
	end

	assign out_valid = valid_s2;
	assign command_id = result_s2.command_id;
	assign payload_value = result_s2.payload_value;
	assign frame_length = result_s2.frame_length;
endmodule
`default_nettype wire
